// ===== src/gbm_pkg.sv =====
// ----------------------------------------------------------------------------
// gbm_pkg
// shared types, constants and coefficient table for the gbm path step core
// ----------------------------------------------------------------------------
`default_nettype none

package gbm_pkg;

    localparam int unsigned GBM_QUEUE_DEPTH = 2;
    localparam int unsigned MAX_STEPS       = 65535;

    // configuration register indexes
    localparam logic [2:0] REG_START_PRICE = 3'd0;
    localparam logic [2:0] REG_DRIFT       = 3'd1;
    localparam logic [2:0] REG_VOL         = 3'd2;
    localparam logic [2:0] REG_STEPS       = 3'd3;
    localparam logic [2:0] REG_PATHS       = 3'd4;

    localparam logic [31:0] START_PRICE_RST = 32'd6553600;
    localparam logic [15:0] STEPS_RST       = 16'd252;
    localparam logic [15:0] PATHS_RST       = 16'd1000;

    // log2(e) in q2.30
    localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;
    // highest horner coefficient, q0.30
    localparam logic [32:0] POW2_C6   = 33'd16378;
    localparam int unsigned HORNER_TERMS = 7;

    typedef struct packed {
        logic [31:0]        start_price;
        logic signed [31:0] drift;
        logic [30:0]        vol;
        logic [15:0]        steps;
        logic [15:0]        paths;
    } gbm_cfg_t;

    typedef struct packed {
        logic [27:0] factor;
        logic        sat;
    } gbm_entry_t;

    // term added after each horner product: c5 .. c0, then one in q.30
    function automatic logic [31:0] horner_term(input logic [2:0] idx);
        logic [31:0] t;
        begin
            case (idx)
                3'd0:    t = 32'd165394;
                3'd1:    t = 32'd1431680;
                3'd2:    t = 32'd10327387;
                3'd3:    t = 32'd59597083;
                3'd4:    t = 32'd257941248;
                3'd5:    t = 32'd744261118;
                3'd6:    t = 32'd1073741824;
                default: t = 32'd0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/gbm_front.sv =====
// ----------------------------------------------------------------------------
// gbm_front
// takes one shock beat and works out the growth factor on a shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gbm_pkg::gbm_cfg_t cfg,
    input  wire logic              z_valid,
    output logic                   z_stall,
    input  wire logic signed [15:0] z,
    output logic                   push,
    output gbm_pkg::gbm_entry_t    push_data,
    input  wire logic              q_full
);
    import gbm_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MZ   = 3'd1;
    localparam logic [2:0] F_PE   = 3'd2;
    localparam logic [2:0] F_MY   = 3'd3;
    localparam logic [2:0] F_PY   = 3'd4;
    localparam logic [2:0] F_MH   = 3'd5;
    localparam logic [2:0] F_PH   = 3'd6;
    localparam logic [2:0] F_SH   = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic signed [32:0] a_reg, a_next;
    logic signed [32:0] b_reg, b_next;
    logic signed [65:0] prod_reg;
    logic               sat_reg, sat_next;
    logic [4:0]         k_reg, k_next;
    logic [29:0]        f_reg, f_next;
    logic [2:0]         hidx_reg, hidx_next;
    logic [31:0]        p_reg, p_next;

    logic [47:0]        acc;
    logic [32:0]        e_full;
    logic [30:0]        e_clamp;
    logic               e_sat;
    logic [31:0]        h_sum;
    logic [4:0]         shamt;
    logic [32:0]        rnd;
    logic [32:0]        shifted;

    // exponent: drift*2^12 + vol*z, round half up to q.27, clamp to [-8, 8)
    always_comb
    begin
        acc    = prod_reg[47:0] + {{4{cfg.drift[31]}}, cfg.drift, 12'd0} + 48'd16384;
        e_full = acc[47:15];
        e_sat  = 1'b0;
        if (!e_full[32] && (e_full[31:30] != 2'b00))
        begin
            e_clamp = 31'h3FFF_FFFF;
            e_sat   = 1'b1;
        end
        else if (e_full[32] && (e_full[31:30] != 2'b11))
        begin
            e_clamp = 31'h4000_0000;
            e_sat   = 1'b1;
        end
        else
        begin
            e_clamp = e_full[30:0];
        end
    end

    assign h_sum   = horner_term(hidx_reg) + prod_reg[61:30];
    assign shamt   = 5'd14 - k_reg;
    assign rnd     = {1'b0, p_reg} + (33'd1 << (shamt - 5'd1));
    assign shifted = rnd >> shamt;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sat_next   = sat_reg;
        k_next     = k_reg;
        f_next     = f_reg;
        hidx_next  = hidx_reg;
        p_next     = p_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (z_valid)
                begin
                    a_next     = {2'b00, cfg.vol};
                    b_next     = {{17{z[15]}}, z};
                    state_next = F_MZ;
                end
            end
            F_MZ: state_next = F_PE;
            F_PE:
            begin
                sat_next   = e_sat;
                a_next     = {{2{e_clamp[30]}}, e_clamp};
                b_next     = LOG2E_Q30;
                state_next = F_MY;
            end
            F_MY: state_next = F_PY;
            F_PY:
            begin
                k_next     = prod_reg[61:57];
                f_next     = prod_reg[56:27];
                a_next     = POW2_C6;
                b_next     = {3'b000, prod_reg[56:27]};
                hidx_next  = 3'd0;
                state_next = F_MH;
            end
            F_MH: state_next = F_PH;
            F_PH:
            begin
                if (hidx_reg == 3'(HORNER_TERMS - 1))
                begin
                    p_next     = h_sum;
                    state_next = F_SH;
                end
                else
                begin
                    a_next     = {1'b0, h_sum};
                    b_next     = {3'b000, f_reg};
                    hidx_next  = hidx_reg + 3'd1;
                    state_next = F_MH;
                end
            end
            F_SH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign z_stall          = (state_reg != F_IDLE);
    assign push_data.factor = shifted[27:0];
    assign push_data.sat    = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= a_reg * b_reg;
        sat_reg  <= sat_next;
        k_reg    <= k_next;
        f_reg    <= f_next;
        hidx_reg <= hidx_next;
        p_reg    <= p_next;
    end

endmodule

`default_nettype wire

// ===== src/gbm_queue.sv =====
// ----------------------------------------------------------------------------
// gbm_queue
// small register queue of growth factors between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_queue #(
    parameter int unsigned DEPTH = gbm_pkg::GBM_QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire gbm_pkg::gbm_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output gbm_pkg::gbm_entry_t      pop_data,
    output logic                     empty
);
    import gbm_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    gbm_entry_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (do_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== src/gbm_back.sv =====
// ----------------------------------------------------------------------------
// gbm_back
// applies the growth factor to the path price and keeps step and path counts
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gbm_pkg::gbm_cfg_t   cfg,
    input  wire logic                empty,
    output logic                     pop,
    input  wire gbm_pkg::gbm_entry_t pop_data,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [31:0]              price,
    output logic [15:0]              step_index,
    output logic [15:0]              path_index,
    output logic                     last_of_path,
    output logic                     last_of_run,
    output logic                     saturated
);
    import gbm_pkg::*;

    logic        busy_reg;
    logic [59:0] prod_reg;
    logic        esat_reg;
    logic [31:0] cur_price_reg;
    logic [15:0] step_cnt_reg;
    logic [15:0] path_cnt_reg;
    logic        out_valid_reg;
    logic [31:0] price_reg;
    logic [15:0] step_idx_reg;
    logic [15:0] path_idx_reg;
    logic        lop_reg, lor_reg, sat_reg;

    logic [31:0] base;
    logic [60:0] np_full;
    logic        np_ovf;
    logic [31:0] np;
    logic [15:0] steps_eff, paths_eff;
    logic [16:0] step_p1, path_p1;
    logic        end_path, end_run, finish;

    assign base    = (step_cnt_reg == 16'd0) ? cfg.start_price : cur_price_reg;
    assign pop     = !busy_reg && !empty;
    assign np_full = {1'b0, prod_reg} + 61'd32768;
    assign np_ovf  = (np_full[60:48] != 13'd0);
    assign np      = np_ovf ? 32'hFFFF_FFFF : np_full[47:16];

    always_comb
    begin
        steps_eff = (cfg.steps == 16'd0) ? 16'd1 : cfg.steps;
        if ({1'b0, steps_eff} > 17'(MAX_STEPS))
            steps_eff = 16'(MAX_STEPS);
        paths_eff = (cfg.paths == 16'd0) ? 16'd1 : cfg.paths;
    end

    assign step_p1  = {1'b0, step_cnt_reg} + 17'd1;
    assign path_p1  = {1'b0, path_cnt_reg} + 17'd1;
    assign end_path = step_p1 >= {1'b0, steps_eff};
    assign end_run  = end_path && (path_p1 >= {1'b0, paths_eff});
    assign finish   = busy_reg && (!out_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            step_cnt_reg  <= '0;
            path_cnt_reg  <= '0;
            cur_price_reg <= START_PRICE_RST;
        end
        else
        begin
            if (pop)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                if (end_path)
                begin
                    step_cnt_reg  <= '0;
                    cur_price_reg <= cfg.start_price;
                    path_cnt_reg  <= end_run ? 16'd0 : path_p1[15:0];
                end
                else
                begin
                    step_cnt_reg  <= step_p1[15:0];
                    cur_price_reg <= np;
                end
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg <= base * pop_data.factor;
            esat_reg <= pop_data.sat;
        end
        if (finish)
        begin
            price_reg    <= np;
            step_idx_reg <= step_p1[15:0];
            path_idx_reg <= path_cnt_reg;
            lop_reg      <= end_path;
            lor_reg      <= end_run;
            sat_reg      <= esat_reg || np_ovf;
        end
    end

    assign res_valid    = out_valid_reg;
    assign price        = price_reg;
    assign step_index   = step_idx_reg;
    assign path_index   = path_idx_reg;
    assign last_of_path = lop_reg;
    assign last_of_run  = lor_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire

// ===== src/gbm_path_step_generator_core.sv =====
// ----------------------------------------------------------------------------
// gbm_path_step_generator_core
// geometric brownian motion price stepper: one shock beat in, one price out
// ----------------------------------------------------------------------------
// flow: the front sequencer takes a shock beat, works out the factor and pushes
//   it into the queue; the back pops it, registers the price product and then
//   the price beat; the front takes no new shock beat until it has pushed its
//   factor, running nine products through its single shared multiplier
// the back multiply and the queue overlap with the next item's front work
// reset: asynchronous active low; registers take their documented defaults,
//   counters clear and the next beat starts path 0 at step 1
`default_nettype none

module gbm_path_step_generator_core #(
    parameter int unsigned QUEUE_DEPTH = gbm_pkg::GBM_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // shock channel
    input  wire logic               z_valid,
    output logic                    z_stall,
    input  wire logic signed [15:0] z,
    // result channel
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [31:0]             price,
    output logic [15:0]             step_index,
    output logic [15:0]             path_index,
    output logic                    last_of_path,
    output logic                    last_of_run,
    output logic                    saturated
);
    import gbm_pkg::*;

    gbm_cfg_t   cfg_reg;
    gbm_entry_t push_data, pop_data;
    logic       push, pop, q_full, q_empty;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_price <= START_PRICE_RST;
            cfg_reg.drift       <= '0;
            cfg_reg.vol         <= '0;
            cfg_reg.steps       <= STEPS_RST;
            cfg_reg.paths       <= PATHS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_PRICE: cfg_reg.start_price <= cfg_data;
                REG_DRIFT:       cfg_reg.drift       <= cfg_data;
                REG_VOL:         cfg_reg.vol         <= cfg_data[30:0];
                REG_STEPS:       cfg_reg.steps       <= cfg_data[15:0];
                REG_PATHS:       cfg_reg.paths       <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // front: exponent, base-2 split and polynomial, growth factor
    gbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .z_valid   (z_valid),
        .z_stall   (z_stall),
        .z         (z),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // decouples the factor sequencer from the price recurrence
    gbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // back: price multiply, saturation, step and path counters, output beat
    gbm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (q_empty),
        .pop          (pop),
        .pop_data     (pop_data),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .price        (price),
        .step_index   (step_index),
        .path_index   (path_index),
        .last_of_path (last_of_path),
        .last_of_run  (last_of_run),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

// ===== src/gbm_chk.sv =====
// ----------------------------------------------------------------------------
// gbm_chk
// port level checks on the gbm path step core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [31:0] price,
    input wire logic [15:0] step_index,
    input wire logic        last_of_path,
    input wire logic        last_of_run
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(price))
        else $error("stalled result beat changed");

    // end of run only on an end of path
    a_run_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_of_run |-> last_of_path)
        else $error("last_of_run without last_of_path");

    // step numbers count from one
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> step_index != 16'd0)
        else $error("step index zero");

    // after a path ends the next beat opens a new path
    a_new_path: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && last_of_path |=> !res_valid || step_index == 16'd1)
        else $error("path did not restart at step one");

endmodule

bind gbm_path_step_generator_core gbm_chk u_gbm_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .price        (price),
    .step_index   (step_index),
    .last_of_path (last_of_path),
    .last_of_run  (last_of_run)
);

`default_nettype wire

// ===== sim/gbm_path_step_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// gbm_path_step_generator_core_tb
// self-checking bench: random shocks and register settings through the gbm
// stepper, every price beat checked against an in-bench predictor
// ----------------------------------------------------------------------------
`default_nettype none

module gbm_path_step_generator_core_tb;

    import gbm_pkg::*;

    // one expected price beat
    typedef struct packed {
        logic [31:0] price;
        logic [15:0] step_index;
        logic [15:0] path_index;
        logic        last_of_path;
        logic        last_of_run;
        logic        saturated;
    } price_beat_t;

    // pending shock beat, or a pause marker for the driver
    typedef struct packed {
        logic        drain;
        logic [15:0] shock;
    } shock_item_t;

    localparam longint CYCLE_LIMIT = 1500000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               z_valid;
    logic               z_stall;
    logic signed [15:0] z;
    logic               res_valid;
    logic               res_stall;
    logic [31:0]        price;
    logic [15:0]        step_index;
    logic [15:0]        path_index;
    logic               last_of_path;
    logic               last_of_run;
    logic               saturated;

    gbm_path_step_generator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .z_valid      (z_valid),
        .z_stall      (z_stall),
        .z            (z),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .price        (price),
        .step_index   (step_index),
        .path_index   (path_index),
        .last_of_path (last_of_path),
        .last_of_run  (last_of_run),
        .saturated    (saturated)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // predictor copy of the registers and the path state
    logic [31:0]        mdl_start;
    logic signed [31:0] mdl_drift;
    logic [30:0]        mdl_vol;
    logic [15:0]        mdl_steps;
    logic [15:0]        mdl_paths;
    logic [31:0]        mdl_price;
    logic [15:0]        mdl_step_cnt;
    logic [15:0]        mdl_path_cnt;

    shock_item_t pending_shocks[$];
    price_beat_t expected_prices[$];

    int     error_count = 0;
    bit     quiet_tail  = 0;   // no idling in the last part of the run
    longint cycle_count = 0;

    // growth factor exp(e) in q16.16, e in q.27
    function automatic logic [63:0] growth_factor(input longint e);
        longint      prod;
        longint      y;
        longint      k;
        logic [63:0] f;
        logic [63:0] p;
        int          s;
        logic [63:0] coef [0:6];
        begin
            coef[0] = 744261118; coef[1] = 257941248; coef[2] = 59597083;
            coef[3] = 10327387;  coef[4] = 1431680;   coef[5] = 165394;
            coef[6] = 16378;
            prod = e * 64'sd1549082005;
            y = prod >>> 27;               // floor division
            k = y >>> 30;
            f = 64'(y - (k <<< 30));
            p = coef[6];
            for (int i = 5; i >= 0; i--)
                p = coef[i] + ((p * f) >> 30);
            p = (64'd1 << 30) + ((p * f) >> 30);
            s = 14 - int'(k);
            if (s < 1) s = 1;
            if (s > 62) s = 62;
            return (p + (64'd1 << (s - 1))) >> s;
        end
    endfunction

    // advance the path by one shock and queue the price beat it causes
    function automatic void predict_price(input logic signed [15:0] shock);
        longint      acc;
        longint      e;
        logic [63:0] base;
        logic [63:0] np;
        logic [16:0] steps;
        logic [16:0] paths;
        bit          sat;
        bit          end_path;
        bit          end_run;
        price_beat_t b;
        begin
            sat   = 0;
            steps = (mdl_steps == 0) ? 17'd1 : {1'b0, mdl_steps};
            paths = (mdl_paths == 0) ? 17'd1 : {1'b0, mdl_paths};
            acc = longint'(mdl_drift) * 4096 + longint'({1'b0, mdl_vol}) * longint'(shock);
            e = (acc + 16384) >>> 15;
            if (e > 64'sd1073741823)  begin e = 64'sd1073741823;  sat = 1; end
            if (e < -64'sd1073741824) begin e = -64'sd1073741824; sat = 1; end
            base = (mdl_step_cnt == 0) ? 64'(mdl_start) : 64'(mdl_price);
            np = (base * growth_factor(e) + 64'd32768) >> 16;
            if (np > 64'hFFFF_FFFF) begin np = 64'hFFFF_FFFF; sat = 1; end
            end_path = ({1'b0, mdl_step_cnt} + 17'd1) >= steps;
            end_run  = end_path && (({1'b0, mdl_path_cnt} + 17'd1) >= paths);
            b.price        = np[31:0];
            b.step_index   = mdl_step_cnt + 16'd1;
            b.path_index   = mdl_path_cnt;
            b.last_of_path = end_path;
            b.last_of_run  = end_run;
            b.saturated    = sat;
            expected_prices.insert(expected_prices.size(), b);
            if (end_path) begin
                mdl_step_cnt = 0;
                mdl_price    = mdl_start;
                mdl_path_cnt = end_run ? 16'd0 : mdl_path_cnt + 16'd1;
            end
            else begin
                mdl_step_cnt = mdl_step_cnt + 16'd1;
                mdl_price    = np[31:0];
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // shock driver: pops pending beats, idles in random bursts, and on a
    // drain marker holds off until every expected price has come back
    // ------------------------------------------------------------------
    int drv_idle;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            z_valid  <= 1'b0;
            z        <= '0;
            drv_idle <= 0;
        end
        else begin
            if (!(z_valid && z_stall)) begin
                // current beat taken (or none held): choose the next one
                if (z_valid)
                    predict_price(z);
                if (drv_idle > 0) begin
                    drv_idle <= drv_idle - 1;
                    z_valid  <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    drv_idle <= $urandom_range(0, 6);
                    z_valid  <= 1'b0;
                end
                else if (pending_shocks.size() > 0 && pending_shocks[0].drain) begin
                    z_valid <= 1'b0;
                    if (expected_prices.size() == 0 && !(z_valid))
                        void'(pending_shocks.pop_front());
                end
                else if (pending_shocks.size() > 0) begin
                    z_valid <= 1'b1;
                    z       <= pending_shocks[0].shock;
                    void'(pending_shocks.pop_front());
                end
                else
                    z_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // price monitor: random stall bursts, compares every accepted beat
    // ------------------------------------------------------------------
    int mon_stall;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            mon_stall <= 0;
        end
        else begin
            cycle_count <= cycle_count + 1;
            if (res_valid && !res_stall) begin
                if (expected_prices.size() == 0) begin
                    $display("%0t: unexpected price beat %h", $time, price);
                    error_count = error_count + 1;
                end
                else begin
                    price_beat_t x;
                    x = expected_prices.pop_front();
                    if (x.price !== price) begin
                        $display("%0t: price exp %h got %h", $time, x.price, price);
                        error_count = error_count + 1;
                    end
                    if (x.step_index !== step_index) begin
                        $display("%0t: step_index exp %0d got %0d", $time,
                                 x.step_index, step_index);
                        error_count = error_count + 1;
                    end
                    if (x.path_index !== path_index) begin
                        $display("%0t: path_index exp %0d got %0d", $time,
                                 x.path_index, path_index);
                        error_count = error_count + 1;
                    end
                    if (x.last_of_path !== last_of_path) begin
                        $display("%0t: last_of_path exp %b got %b", $time,
                                 x.last_of_path, last_of_path);
                        error_count = error_count + 1;
                    end
                    if (x.last_of_run !== last_of_run) begin
                        $display("%0t: last_of_run exp %b got %b", $time,
                                 x.last_of_run, last_of_run);
                        error_count = error_count + 1;
                    end
                    if (x.saturated !== saturated) begin
                        $display("%0t: saturated exp %b got %b", $time,
                                 x.saturated, saturated);
                        error_count = error_count + 1;
                    end
                end
            end
            if (mon_stall > 0) begin
                mon_stall <= mon_stall - 1;
                res_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                mon_stall <= $urandom_range(0, 6);
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // timeout guard
    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // wait until the block is idle with nothing outstanding
    task automatic wait_idle();
        begin
            while (pending_shocks.size() > 0 || z_valid || expected_prices.size() > 0)
                @(posedge clk);
            // the core has no dropped items but allow its pipeline to settle
            repeat (30) @(posedge clk);
        end
    endtask

    // register write through the config channel, model updated on acceptance
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
            case (idx)
                REG_START_PRICE: mdl_start = val;
                REG_DRIFT:       mdl_drift = val;
                REG_VOL:         mdl_vol   = val[30:0];
                REG_STEPS:       mdl_steps = val[15:0];
                REG_PATHS:       mdl_paths = val[15:0];
                default: ;
            endcase
        end
    endtask

    task automatic push_shock(input logic [15:0] s);
        shock_item_t it;
        begin
            it.drain = 1'b0;
            it.shock = s;
            pending_shocks.insert(pending_shocks.size(), it);
        end
    endtask

    // realistic shock: mostly within a few sigma, sometimes any code
    function automatic logic [15:0] rand_shock();
        begin
            if ($urandom_range(0, 9) == 0)
                return 16'($urandom);
            return 16'($signed($urandom_range(0, 24576)) - 12288);
        end
    endfunction

    initial begin
        shock_item_t pause;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        mdl_start = START_PRICE_RST;
        mdl_drift = 0;
        mdl_vol   = 0;
        mdl_steps = STEPS_RST;
        mdl_paths = PATHS_RST;
        mdl_price = START_PRICE_RST;
        mdl_step_cnt = 0;
        mdl_path_cnt = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: zero exponent, price should hold
        push_shock(16'h0000);
        push_shock(16'h7FFF);
        wait_idle();

        // directed: short paths and runs, field extremes, saturation both ways
        write_reg(REG_STEPS, 32'd3);
        write_reg(REG_PATHS, 32'd2);
        write_reg(REG_VOL, 32'hFFFF_FFFF);          // sign bit dropped
        write_reg(REG_DRIFT, 32'h7FFF_FFFF);
        push_shock(16'h7FFF);                       // exponent clamps high
        push_shock(16'h8000);
        push_shock(16'hFFFF);
        push_shock(16'h0001);
        wait_idle();
        write_reg(REG_DRIFT, 32'h8000_0000);
        write_reg(REG_START_PRICE, 32'hFFFF_FFFF);  // written mid path
        push_shock(16'h8000);                       // exponent clamps low
        push_shock(16'h5555);
        push_shock(16'hAAAA);
        wait_idle();
        write_reg(REG_START_PRICE, 32'hFFFF_FFFF);
        write_reg(REG_DRIFT, 32'h0800_0000);
        write_reg(REG_VOL, 32'd0);
        for (int i = 0; i < 4; i++) push_shock(16'h0000);  // price overflow
        wait_idle();
        // zero counts act as one; lowering steps mid path ends it
        write_reg(REG_START_PRICE, 32'd0);
        write_reg(REG_STEPS, 32'd0);
        write_reg(REG_PATHS, 32'd0);
        push_shock(16'h1234);
        push_shock(16'hEDCB);
        wait_idle();
        write_reg(REG_STEPS, 32'd65535);
        write_reg(REG_PATHS, 32'd65535);
        write_reg(REG_START_PRICE, 32'd1);
        push_shock(16'h0100);
        wait_idle();

        // random phases with varied settings, realistic drift and vol
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_START_PRICE, (ph % 3 == 0) ? $urandom : $urandom_range(1, 32'h0100_0000));
            write_reg(REG_DRIFT, (ph == 4) ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000));
            write_reg(REG_VOL, (ph == 5) ? $urandom : $urandom_range(0, 40000000));
            write_reg(REG_STEPS, (ph == 6) ? 32'd65535 : $urandom_range(1, 12));
            write_reg(REG_PATHS, (ph == 7) ? 32'd65535 : $urandom_range(1, 5));
            if (ph == 9) quiet_tail = 1;
            for (int i = 0; i < 62; i++) begin
                push_shock(rand_shock());
                if (ph == 2 && i == 30) begin
                    pause.drain = 1'b1;
                    pause.shock = '0;
                    pending_shocks.insert(pending_shocks.size(), pause);
                end
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
